### design/sleep_shutdown_timer_defines.svh
// ---------------------------------------------------------------------------
// Sleep and shutdown timer: assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SLEEP_SHUTDOWN_TIMER_DEFINES_SVH
`define SLEEP_SHUTDOWN_TIMER_DEFINES_SVH

// same-cycle implication
`define SST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sleep_shutdown_timer: same-cycle check failed");

// next-cycle implication
`define SST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sleep_shutdown_timer: next-cycle check failed");

`endif

### design/sst_pkg.sv
// ---------------------------------------------------------------------------
// Sleep and shutdown timer: package
// Item types, status handoff struct, event and register codes.
// ---------------------------------------------------------------------------
package sst_pkg;

	// event kinds
	localparam logic [2:0] KIND_TICK     = 3'd0;
	localparam logic [2:0] KIND_SET      = 3'd1;
	localparam logic [2:0] KIND_CYCLE    = 3'd2;
	localparam logic [2:0] KIND_CANCEL   = 3'd3;
	localparam logic [2:0] KIND_ACTIVITY = 3'd4;
	localparam logic [2:0] KIND_REQUEST  = 3'd5;

	// shutdown causes
	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_SLEEP   = 2'd1;
	localparam logic [1:0] CAUSE_REQUEST = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_SCREEN_OFF = 3'd0;
	localparam logic [2:0] CFG_PRESET_1   = 3'd1;
	localparam logic [2:0] CFG_PRESET_2   = 3'd2;
	localparam logic [2:0] CFG_PRESET_3   = 3'd3;
	localparam logic [2:0] CFG_PRESET_4   = 3'd4;

	localparam int unsigned CFG_DATA_W = 20;

	// remaining-seconds saturation
	localparam logic [16:0] REMAIN_MAX     = 17'd131071;
	localparam logic [31:0] REMAIN_MAX_MS  = 32'd131071000;

	typedef enum logic [1:0] {
		REM_ZERO   = 2'd0,
		REM_DIRECT = 2'd1,
		REM_SAT    = 2'd2,
		REM_DIV    = 2'd3
	} rem_mode_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] now_ms;
		logic        backlight_on;
		logic [10:0] minutes;
		logic [30:0] req_delay;
	} in_item_t;

	typedef struct packed {
		logic        screen_off_cmd;
		logic        shutdown_cmd;
		logic [1:0]  shutdown_cause;
		logic        timer_active;
		logic [10:0] preset_minutes;
		logic [16:0] remaining_seconds;
	} out_item_t;

	typedef struct packed {
		logic [19:0]      screen_off_wait;
		logic [3:0][10:0] presets;
	} cfg_t;

	// status after one item; amount holds minutes (direct) or ms to deadline (div)
	typedef struct packed {
		logic        scr;
		logic        shut;
		logic [1:0]  cause;
		logic        active;
		logic [10:0] preset;
		rem_mode_t   mode;
		logic [26:0] amount;
	} stat_t;

endpackage

### design/sst_ctrl.sv
// ---------------------------------------------------------------------------
// Sleep and shutdown timer: event controller
// Timer state, deadline compares and per-item status.
// ---------------------------------------------------------------------------
module sst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  sst_pkg::in_item_t item,
	input  sst_pkg::cfg_t     cfg,
	output sst_pkg::stat_t    stat
);

	logic        active_q,  active_d;
	logic        started_q, started_d;
	logic [10:0] preset_q,  preset_d;
	logic [31:0] sleep_dl_q, sleep_dl_d;
	logic        armed_q,   armed_d;
	logic        last_bl_q, last_bl_d;
	logic [31:0] so_dl_q,   so_dl_d;
	logic        req_q,     req_d;
	logic [31:0] req_dl_q,  req_dl_d;

	logic        bl;
	logic [31:0] now;
	logic [31:0] delay32;
	logic [31:0] so_new;
	logic        rise;
	logic        so_fire;
	logic        req_due;
	logic        sleep_due;
	logic [31:0] ms_left;
	logic [10:0] cur;
	logic [10:0] cycle_next;
	logic        set_go;
	logic [10:0] set_m;
	logic [26:0] span;
	logic        scr;
	logic        shut;
	logic [1:0]  cause;

	// signed wrap compare: now at or past deadline
	function automatic logic reached(input logic [31:0] t, input logic [31:0] dl);
		logic [31:0] diff;
		diff = t - dl;
		return ~diff[31];
	endfunction

	assign bl        = item.backlight_on;
	assign now       = item.now_ms;
	assign delay32   = {12'd0, cfg.screen_off_wait};
	assign so_new    = now + delay32;
	assign rise      = bl && !last_bl_q;
	// on a rising edge the fresh deadline is due only for a zero delay
	assign so_fire   = bl && (rise ? (cfg.screen_off_wait == 20'd0)
	                               : (armed_q && reached(now, so_dl_q)));
	assign req_due   = req_q && reached(now, req_dl_q);
	assign sleep_due = reached(now, sleep_dl_q);
	assign ms_left   = sleep_dl_q - now;
	assign cur       = active_q ? preset_q : 11'd0;

	// preset list 0, p1..p4, first match, next entry wraps to 0
	always_comb begin
		if (cur == 11'd0) begin
			cycle_next = cfg.presets[0];
		end else if (cur == cfg.presets[0]) begin
			cycle_next = cfg.presets[1];
		end else if (cur == cfg.presets[1]) begin
			cycle_next = cfg.presets[2];
		end else if (cur == cfg.presets[2]) begin
			cycle_next = cfg.presets[3];
		end else if (cur == cfg.presets[3]) begin
			cycle_next = 11'd0;
		end else begin
			cycle_next = cfg.presets[0];
		end
	end

	assign set_m = (item.kind == sst_pkg::KIND_SET) ? item.minutes : cycle_next;
	assign span  = 27'(set_m) * 27'd60000;

	always_comb begin
		active_d   = active_q;
		started_d  = started_q;
		preset_d   = preset_q;
		sleep_dl_d = sleep_dl_q;
		armed_d    = armed_q;
		last_bl_d  = last_bl_q;
		so_dl_d    = so_dl_q;
		req_d      = req_q;
		req_dl_d   = req_dl_q;
		scr        = 1'b0;
		shut       = 1'b0;
		cause      = sst_pkg::CAUSE_NONE;
		set_go     = 1'b0;

		if (!started_q) begin
			case (item.kind)
				sst_pkg::KIND_TICK: begin
					if (req_due) begin
						shut  = 1'b1;
						cause = sst_pkg::CAUSE_REQUEST;
					end else if (active_q) begin
						if (rise) begin
							armed_d = 1'b1;
							so_dl_d = so_new;
						end else if (!bl) begin
							armed_d = 1'b0;
							so_dl_d = 32'd0;
						end
						last_bl_d = bl;
						if (so_fire) begin
							scr       = 1'b1;
							armed_d   = 1'b0;
							so_dl_d   = 32'd0;
							last_bl_d = 1'b0;
						end
						if (sleep_due) begin
							shut  = 1'b1;
							cause = sst_pkg::CAUSE_SLEEP;
						end
					end
					if (shut) begin
						active_d   = 1'b0;
						preset_d   = 11'd0;
						sleep_dl_d = 32'd0;
						armed_d    = 1'b0;
						so_dl_d    = 32'd0;
						req_d      = 1'b0;
						req_dl_d   = 32'd0;
						started_d  = 1'b1;
					end
				end
				sst_pkg::KIND_SET, sst_pkg::KIND_CYCLE: begin
					set_go = 1'b1;
				end
				sst_pkg::KIND_CANCEL: begin
					active_d   = 1'b0;
					preset_d   = 11'd0;
					sleep_dl_d = 32'd0;
					armed_d    = 1'b0;
					so_dl_d    = 32'd0;
					last_bl_d  = bl;
				end
				sst_pkg::KIND_ACTIVITY: begin
					if (active_q && bl) begin
						armed_d   = 1'b1;
						so_dl_d   = so_new;
						last_bl_d = 1'b1;
					end
				end
				sst_pkg::KIND_REQUEST: begin
					req_d    = 1'b1;
					req_dl_d = now + {1'b0, item.req_delay};
				end
				default: begin
				end
			endcase
		end

		if (set_go) begin
			last_bl_d = bl;
			if (set_m == 11'd0) begin
				active_d   = 1'b0;
				preset_d   = 11'd0;
				sleep_dl_d = 32'd0;
				armed_d    = 1'b0;
				so_dl_d    = 32'd0;
			end else begin
				active_d   = 1'b1;
				preset_d   = set_m;
				sleep_dl_d = now + {5'd0, span};
				armed_d    = bl;
				so_dl_d    = bl ? so_new : 32'd0;
			end
		end
	end

	// status for the remaining-seconds stage
	always_comb begin
		stat.scr    = scr;
		stat.shut   = shut;
		stat.cause  = cause;
		stat.active = active_d;
		stat.preset = active_d ? preset_d : 11'd0;
		stat.mode   = sst_pkg::REM_ZERO;
		stat.amount = 27'd0;
		if (active_d) begin
			if (set_go) begin
				// fresh deadline: exactly minutes * 60 s away
				stat.mode   = sst_pkg::REM_DIRECT;
				stat.amount = 27'(set_m);
			end else if (ms_left == 32'd0 || ms_left[31]) begin
				stat.mode = sst_pkg::REM_ZERO;
			end else if (ms_left > sst_pkg::REMAIN_MAX_MS) begin
				stat.mode = sst_pkg::REM_SAT;
			end else begin
				stat.mode   = sst_pkg::REM_DIV;
				stat.amount = ms_left[26:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			started_q  <= 1'b0;
			preset_q   <= 11'd0;
			sleep_dl_q <= 32'd0;
			armed_q    <= 1'b0;
			last_bl_q  <= 1'b1;
			so_dl_q    <= 32'd0;
			req_q      <= 1'b0;
			req_dl_q   <= 32'd0;
		end else if (take) begin
			active_q   <= active_d;
			started_q  <= started_d;
			preset_q   <= preset_d;
			sleep_dl_q <= sleep_dl_d;
			armed_q    <= armed_d;
			last_bl_q  <= last_bl_d;
			so_dl_q    <= so_dl_d;
			req_q      <= req_d;
			req_dl_q   <= req_dl_d;
		end
	end

endmodule

### design/sst_remain.sv
// ---------------------------------------------------------------------------
// Sleep and shutdown timer: remaining seconds
// Rounds milliseconds up to seconds by reciprocal multiply; builds the result.
// ---------------------------------------------------------------------------
module sst_remain (
	input  sst_pkg::stat_t    stat,
	output sst_pkg::out_item_t result
);

	// ceil(2^37 / 1000); exact quotient for every value below 2^27
	localparam int unsigned SHIFT = 37;
	localparam logic [27:0] RECIP = 28'd137438954;

	logic [26:0] biased;
	logic [54:0] prod;
	logic [16:0] by_min;
	logic [16:0] secs;

	assign biased = stat.amount + 27'd999;
	assign prod   = 55'(biased) * 55'(RECIP);
	// minutes * 60 as (m << 6) - (m << 2)
	assign by_min = {stat.amount[10:0], 6'd0} - {4'd0, stat.amount[10:0], 2'd0};

	always_comb begin
		case (stat.mode)
			sst_pkg::REM_ZERO:   secs = 17'd0;
			sst_pkg::REM_DIRECT: secs = by_min;
			sst_pkg::REM_SAT:    secs = sst_pkg::REMAIN_MAX;
			sst_pkg::REM_DIV:    secs = prod[SHIFT+16:SHIFT];
			default:             secs = 17'd0;
		endcase
	end

	assign result.screen_off_cmd    = stat.scr;
	assign result.shutdown_cmd      = stat.shut;
	assign result.shutdown_cause    = stat.cause;
	assign result.timer_active      = stat.active;
	assign result.preset_minutes    = stat.preset;
	assign result.remaining_seconds = secs;

endmodule

### design/sleep_shutdown_timer.sv
// ---------------------------------------------------------------------------
// Sleep and shutdown timer
// Event-driven sleep, screen-off and delayed-shutdown timer, one item a cycle.
// ---------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------
//  in        in_valid / in_stall       in_item   (sst_pkg::in_item_t)
//  out       out_valid / out_stall     out_item  (sst_pkg::out_item_t)
//  config    cfg_we                    cfg_index, cfg_data (write only)
//
//  Throughput is one item per cycle while out_stall is low; items pass the
//  input register (s1), status register (s2) and output register in turn.
//  The timer state updates as an item leaves s1; the reciprocal multiply
//  for remaining seconds sits alone between s2 and the output register.
//  Reset loads default registers (15000 ms, presets 15/30/60/90) and idle state.
//  Each stage advances when the one ahead is empty or moving, so bubbles
//  close up; in_stall rises only when all three stages hold items and
//  out_stall is high.
//
module sleep_shutdown_timer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sst_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output sst_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [sst_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	sst_pkg::cfg_t cfg_q;

	// pipeline
	logic               v_s1;
	sst_pkg::in_item_t  item_s1;
	logic               v_s2;
	sst_pkg::stat_t     stat_s2;
	sst_pkg::stat_t     stat_d;
	sst_pkg::out_item_t result_d;

	logic en_out;
	logic en_s2;
	logic en_s1;
	logic take;

	assign en_out   = !out_valid || !out_stall;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !v_s1 || en_s2;
	assign take     = v_s1 && en_s2;
	assign in_stall = !en_s1;

	// register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_off_wait <= 20'd15000;
			cfg_q.presets[0]      <= 11'd15;
			cfg_q.presets[1]      <= 11'd30;
			cfg_q.presets[2]      <= 11'd60;
			cfg_q.presets[3]      <= 11'd90;
		end else if (cfg_we) begin
			case (cfg_index)
				sst_pkg::CFG_SCREEN_OFF: cfg_q.screen_off_wait <= cfg_data[19:0];
				sst_pkg::CFG_PRESET_1:   cfg_q.presets[0] <= cfg_data[10:0];
				sst_pkg::CFG_PRESET_2:   cfg_q.presets[1] <= cfg_data[10:0];
				sst_pkg::CFG_PRESET_3:   cfg_q.presets[2] <= cfg_data[10:0];
				sst_pkg::CFG_PRESET_4:   cfg_q.presets[3] <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// event decode, deadlines and timer state
	sst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.cfg    (cfg_q),
		.stat   (stat_d)
	);

	// stage 2: status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			stat_s2 <= stat_d;
		end
	end

	// remaining seconds and result assembly
	sst_remain u_remain (
		.stat   (stat_s2),
		.result (result_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			out_item <= result_d;
		end
	end

`include "sleep_shutdown_timer_defines.svh"

	// a shutdown always names its cause and stops the timer
	`SST_ASSERT_NOW(a_shut_cause, out_valid && out_item.shutdown_cmd, out_item.shutdown_cause != sst_pkg::CAUSE_NONE && !out_item.timer_active)
	// idle timer reports nothing left
	`SST_ASSERT_NOW(a_idle_zero, out_valid && !out_item.timer_active, out_item.remaining_seconds == 17'd0 && out_item.preset_minutes == 11'd0)
	// an empty output stage never backs up the input
	`SST_ASSERT_NOW(a_no_false_stall, !out_valid, !in_stall)
	// shutdown latches: the next result cannot be another shutdown
	`SST_ASSERT_NEXT(a_shut_once, out_valid && !out_stall && out_item.shutdown_cmd, !(out_valid && out_item.shutdown_cmd))

endmodule

### sim/sleep_shutdown_timer_tb.sv
// ---------------------------------------------------------------------------
// Sleep and shutdown timer: testbench
// Drives timestamped timer events through the valid/stall input channel,
// predicts every status item with a cycle-free model of the timer state
// and compares the status channel field by field. Runs a directed opener,
// random event streams under four idling phases and register settings,
// a long output hold-off, and ends on one shutdown followed by latched
// events.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module sleep_shutdown_timer_tb;

	localparam int HOLD_CYCLES  = 200;  // long output hold-off
	localparam int DRAIN_CYCLES = 8;    // three-stage pipe plus margin
	localparam int PHASE_ITEMS  = 360;

	// timer state as the predictor tracks it
	typedef struct packed {
		bit        active;
		bit        latched;
		bit        scr_armed;
		bit        last_bl;
		bit        req_pend;
		bit [10:0] preset;
		bit [31:0] sleep_dl;
		bit [31:0] scr_dl;
		bit [31:0] req_dl;
	} timer_state_t;

	// how the run ends; only one shutdown fits in a run with a single reset
	typedef enum int {
		END_REQUEST_WINS,
		END_BOTH_CMDS,
		END_SLEEP,
		END_REQUEST
	} finale_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	sst_pkg::in_item_t   in_item = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	sst_pkg::out_item_t  out_item;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = sst_pkg::CFG_SCREEN_OFF;
	logic [sst_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// register copies shared by both predictor instances
	bit [19:0] scr_delay_cfg;
	bit [10:0] preset_cfg [1:4];

	timer_state_t dut_state;   // advanced as items are accepted
	timer_state_t gen_state;   // advanced as items are queued, used to steer stimulus
	bit [31:0]    gen_now;

	sst_pkg::in_item_t  pending_q [$];
	sst_pkg::out_item_t status_due_q [$];
	sst_pkg::out_item_t want;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen;
	int hold_left;

	int mismatches = 0;
	int items_sent = 0;
	int status_seen = 0;
	int scr_cmds = 0;
	int sat_seen = 0;
	int end_cause = 0;
	finale_t finale;

	sleep_shutdown_timer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// signed wrap compare: the deadline counts as reached unless it is
	// still ahead by at most half the counter range
	function automatic bit deadline_hit(bit [31:0] now, bit [31:0] dl);
		bit [31:0] diff;
		diff = now - dl;
		return !diff[31];
	endfunction

	function automatic void drop_timer(inout timer_state_t s);
		s.active    = 1'b0;
		s.preset    = '0;
		s.sleep_dl  = '0;
		s.scr_armed = 1'b0;
		s.scr_dl    = '0;
	endfunction

	// set-minutes semantics; zero minutes cancels
	function automatic void arm_sleep(inout timer_state_t s, input bit [10:0] mins,
			input bit [31:0] now, input bit bl);
		if (mins == 0) begin
			drop_timer(s);
			s.last_bl = bl;
		end else begin
			s.preset    = mins;
			s.sleep_dl  = now + mins * 32'd60000;
			s.active    = 1'b1;
			s.last_bl   = bl;
			s.scr_armed = bl;
			s.scr_dl    = bl ? now + scr_delay_cfg : 32'd0;
		end
	endfunction

	function automatic sst_pkg::out_item_t advance_timer(inout timer_state_t s,
			input sst_pkg::in_item_t it);
		sst_pkg::out_item_t r;
		bit [31:0] now;
		bit [31:0] d;
		bit [31:0] secs;
		bit [10:0] cur;
		int        idx;
		r   = '0;
		now = it.now_ms;
		if (!s.latched) begin
			case (it.kind)
				sst_pkg::KIND_TICK: begin
					// a due request takes priority and skips the sleep logic
					if (s.req_pend && deadline_hit(now, s.req_dl)) begin
						r.shutdown_cmd   = 1'b1;
						r.shutdown_cause = sst_pkg::CAUSE_REQUEST;
					end else if (s.active) begin
						// backlight rising restarts the inactivity window
						if (it.backlight_on && !s.last_bl) begin
							s.scr_armed = 1'b1;
							s.scr_dl    = now + scr_delay_cfg;
						end else if (!it.backlight_on) begin
							s.scr_armed = 1'b0;
							s.scr_dl    = '0;
						end
						s.last_bl = it.backlight_on;
						if (s.scr_armed && it.backlight_on && deadline_hit(now, s.scr_dl)) begin
							r.screen_off_cmd = 1'b1;
							s.scr_armed      = 1'b0;
							s.scr_dl         = '0;
							s.last_bl        = 1'b0;
						end
						if (deadline_hit(now, s.sleep_dl)) begin
							r.shutdown_cmd   = 1'b1;
							r.shutdown_cause = sst_pkg::CAUSE_SLEEP;
						end
					end
					if (r.shutdown_cmd) begin
						drop_timer(s);
						s.req_pend = 1'b0;
						s.req_dl   = '0;
						s.latched  = 1'b1;
					end
				end
				sst_pkg::KIND_SET: arm_sleep(s, it.minutes, now, it.backlight_on);
				sst_pkg::KIND_CYCLE: begin
					// first match in {0, p1..p4}; scan down so the lowest index wins
					cur = s.active ? s.preset : 11'd0;
					idx = 0;
					for (int i = 4; i >= 1; i--)
						if (cur != 0 && preset_cfg[i] == cur)
							idx = i;
					arm_sleep(s, (idx == 4) ? 11'd0 : preset_cfg[idx + 1], now,
						it.backlight_on);
				end
				sst_pkg::KIND_CANCEL: begin
					drop_timer(s);
					s.last_bl = it.backlight_on;
				end
				sst_pkg::KIND_ACTIVITY: begin
					if (s.active && it.backlight_on) begin
						s.scr_armed = 1'b1;
						s.scr_dl    = now + scr_delay_cfg;
						s.last_bl   = 1'b1;
					end
				end
				sst_pkg::KIND_REQUEST: begin
					s.req_pend = 1'b1;
					s.req_dl   = now + {1'b0, it.req_delay};
				end
				default: ;  // unknown kinds leave the state alone
			endcase
		end
		r.timer_active   = s.active;
		r.preset_minutes = s.active ? s.preset : 11'd0;
		if (s.active) begin
			d = s.sleep_dl - now;
			if (d != 0 && !d[31]) begin
				secs = (d + 32'd999) / 32'd1000;
				r.remaining_seconds = (secs > 32'(sst_pkg::REMAIN_MAX)) ?
					sst_pkg::REMAIN_MAX : secs[16:0];
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Input driver: offers queued items, holds a stalled item steady and
	// predicts the status item of every accepted one
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				status_due_q.push_back(advance_timer(dut_state, in_item));
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_item  <= pending_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stall: random per phase, or a counted hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Status monitor
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (status_due_q.size() == 0) begin
				$display("%0t: status item with none pending, expected nothing, got %h",
					$time, out_item);
				mismatches++;
			end else begin
				want = status_due_q.pop_front();
				check_field("screen_off_cmd", want.screen_off_cmd, out_item.screen_off_cmd);
				check_field("shutdown_cmd", want.shutdown_cmd, out_item.shutdown_cmd);
				check_field("shutdown_cause", want.shutdown_cause, out_item.shutdown_cause);
				check_field("timer_active", want.timer_active, out_item.timer_active);
				check_field("preset_minutes", want.preset_minutes, out_item.preset_minutes);
				check_field("remaining_seconds", want.remaining_seconds,
					out_item.remaining_seconds);
				status_seen++;
				if (want.screen_off_cmd)
					scr_cmds++;
				if (want.remaining_seconds == sst_pkg::REMAIN_MAX)
					sat_seen++;
				if (want.shutdown_cmd)
					end_cause = want.shutdown_cause;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic sst_pkg::in_item_t ev(logic [2:0] kind, logic [31:0] now, logic bl,
			logic [10:0] mins, logic [30:0] delay);
		sst_pkg::in_item_t it;
		it.kind         = kind;
		it.now_ms       = now;
		it.backlight_on = bl;
		it.minutes      = mins;
		it.req_delay    = delay;
		return it;
	endfunction

	// queue order is acceptance order, so the steering copy stays in step
	task automatic queue_item(sst_pkg::in_item_t it);
		void'(advance_timer(gen_state, it));
		pending_q.push_back(it);
	endtask

	// Mostly well-formed events on a slowly advancing clock. A tick that
	// would shut the block down is turned into a far request or a fresh
	// set-minutes, so the random part never reaches the latched state.
	task automatic queue_random_item();
		sst_pkg::in_item_t  it;
		timer_state_t       trial;
		sst_pkg::out_item_t peek;
		int                 pick;
		int unsigned        step;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: step = $urandom_range(2000);
			6, 7, 8:          step = $urandom_range(30000);
			default:          step = $urandom_range(300000);
		endcase
		gen_now         = gen_now + step;
		pick            = $urandom_range(99);
		it.now_ms       = gen_now;
		it.backlight_on = ($urandom_range(9) < 7);
		it.minutes      = 11'($urandom_range(1440));
		it.req_delay    = 31'($urandom);
		if (pick < 45) begin
			it.kind = sst_pkg::KIND_TICK;
		end else if (pick < 55) begin
			it.kind = sst_pkg::KIND_SET;
			if ($urandom_range(9) == 0)
				it.minutes = '0;
		end else if (pick < 63) begin
			it.kind = sst_pkg::KIND_CYCLE;
		end else if (pick < 68) begin
			it.kind = sst_pkg::KIND_CANCEL;
		end else if (pick < 85) begin
			it.kind = sst_pkg::KIND_ACTIVITY;
		end else if (pick < 93) begin
			it.kind = sst_pkg::KIND_REQUEST;
			if ($urandom_range(3) != 0)
				it.req_delay[30] = 1'b1;
		end else begin
			// noise: any kind at any time
			it.kind   = 3'($urandom);
			it.now_ms = $urandom;
		end
		trial = gen_state;
		peek  = advance_timer(trial, it);
		if (peek.shutdown_cmd) begin
			if (peek.shutdown_cause == sst_pkg::CAUSE_REQUEST) begin
				it.kind          = sst_pkg::KIND_REQUEST;
				it.req_delay[30] = 1'b1;
			end else begin
				it.kind    = sst_pkg::KIND_SET;
				it.minutes = 11'($urandom_range(1440, 1));
			end
		end
		queue_item(it);
	endtask

	// sender stops until the pipe is empty and every status item is back;
	// checked at the falling edge so the driver's updates have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || in_valid || status_due_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sst_pkg::CFG_SCREEN_OFF: scr_delay_cfg = val;
			sst_pkg::CFG_PRESET_1:   preset_cfg[1] = val[10:0];
			sst_pkg::CFG_PRESET_2:   preset_cfg[2] = val[10:0];
			sst_pkg::CFG_PRESET_3:   preset_cfg[3] = val[10:0];
			sst_pkg::CFG_PRESET_4:   preset_cfg[4] = val[10:0];
			default: ;
		endcase
	endtask

	task automatic load_config(logic [19:0] scr, logic [10:0] p1, logic [10:0] p2,
			logic [10:0] p3, logic [10:0] p4);
		write_reg(sst_pkg::CFG_SCREEN_OFF, scr);
		write_reg(sst_pkg::CFG_PRESET_1, 20'(p1));
		write_reg(sst_pkg::CFG_PRESET_2, 20'(p2));
		write_reg(sst_pkg::CFG_PRESET_3, 20'(p3));
		write_reg(sst_pkg::CFG_PRESET_4, 20'(p4));
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		bit [31:0]  t0;
		bit [31:0]  dl;
		bit [10:0]  rp [1:4];
		int         send_mix [4];
		int         stall_mix [4];

		send_mix  = '{0, 76, 0, 33};
		stall_mix = '{0, 0, 76, 33};

		// reset values of the registers and the timer
		scr_delay_cfg   = 20'd15000;
		preset_cfg[1]   = 11'd15;
		preset_cfg[2]   = 11'd30;
		preset_cfg[3]   = 11'd60;
		preset_cfg[4]   = 11'd90;
		dut_state         = '0;
		dut_state.last_bl = 1'b1;
		gen_state         = dut_state;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed opener, reset register values ---
		queue_item(ev(sst_pkg::KIND_TICK, 32'd0, 1'b0, 11'd0, 31'd0));   // idle status
		queue_item(ev(3'd6, 32'hFFFF_FFFF, 1'b0, 11'd1440, 31'h7FFF_FFFF)); // unknown kinds
		queue_item(ev(3'd7, 32'd1, 1'b1, 11'd0, 31'd0));
		// cycle through all four presets and wrap back to off
		for (int i = 0; i < 5; i++)
			queue_item(ev(sst_pkg::KIND_CYCLE, 32'(100 * (i + 1)), 1'b1, 11'd0, 31'd0));
		// longest timer, deadline wrapping past zero
		t0 = 32'hFFFF_F000;
		dl = t0 + 32'd86_400_000;
		queue_item(ev(sst_pkg::KIND_SET, t0, 1'b1, 11'd1440, 31'd0));
		queue_item(ev(sst_pkg::KIND_TICK, t0 + 14999, 1'b1, 11'd0, 31'd0)); // short of screen-off
		queue_item(ev(sst_pkg::KIND_TICK, t0 + 15000, 1'b1, 11'd0, 31'd0)); // screen-off fires
		queue_item(ev(sst_pkg::KIND_TICK, t0 + 16000, 1'b0, 11'd0, 31'd0)); // backlight off
		queue_item(ev(sst_pkg::KIND_TICK, t0 + 17000, 1'b1, 11'd0, 31'd0)); // rising edge rearms
		queue_item(ev(sst_pkg::KIND_ACTIVITY, t0 + 20000, 1'b1, 11'd0, 31'd0)); // pushes window
		queue_item(ev(sst_pkg::KIND_TICK, t0 + 32000, 1'b1, 11'd0, 31'd0));
		queue_item(ev(sst_pkg::KIND_ACTIVITY, t0 + 33000, 1'b0, 11'd0, 31'd0)); // dark: no effect
		queue_item(ev(sst_pkg::KIND_TICK, t0 + 35000, 1'b1, 11'd0, 31'd0)); // screen-off again
		// clock running backwards: countdown saturates
		queue_item(ev(sst_pkg::KIND_TICK, t0 - 32'd500_000_000, 1'b0, 11'd0, 31'd0));
		queue_item(ev(sst_pkg::KIND_TICK, dl - 1, 1'b1, 11'd0, 31'd0));     // rounds up to one
		queue_item(ev(sst_pkg::KIND_TICK, dl - 1001, 1'b1, 11'd0, 31'd0));  // rounds up to two
		queue_item(ev(sst_pkg::KIND_CANCEL, 32'd0, 1'b1, 11'd0, 31'd0));
		queue_item(ev(sst_pkg::KIND_SET, 32'd5, 1'b0, 11'd0, 31'd0));       // zero minutes cancels
		queue_item(ev(sst_pkg::KIND_REQUEST, 32'd0, 1'b1, 11'd0, 31'h7FFF_FFFF)); // farthest
		queue_item(ev(sst_pkg::KIND_TICK, 32'd1000, 1'b1, 11'd0, 31'd0));
		queue_item(ev(sst_pkg::KIND_ACTIVITY, 32'hFFFF_FFFF, 1'b1, 11'd1440, 31'd0)); // no timer
		wait_drained();

		// --- random phases, each with its own register set and idling mix ---
		gen_now = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: load_config(20'd0, 11'd1, 11'd2, 11'd3, 11'd4);
				1: load_config(20'd600000, 11'd1440, 11'd1440, 11'd1440, 11'd1440);
				default: begin
					for (int i = 1; i <= 4; i++)
						rp[i] = 11'($urandom_range(1440, 1));
					if ($urandom_range(2) == 0)
						rp[3] = rp[2];  // equal presets stick on the first match
					load_config(20'($urandom_range(60000)), rp[1], rp[2], rp[3], rp[4]);
				end
			endcase
			send_idle_pct = send_mix[ph];
			stall_pct     = stall_mix[ph];
			if (ph == 0) begin
				// output held off while the sender keeps offering: the pipe fills
				hold_req++;
				repeat (60) queue_random_item();
				wait_drained();
			end
			repeat (PHASE_ITEMS) queue_random_item();
			wait_drained();
		end

		// --- one shutdown, then events against the latched block ---
		finale = finale_t'($urandom_range(3));
		t0     = gen_now + 1000;
		case (finale)
			END_REQUEST_WINS: begin
				queue_item(ev(sst_pkg::KIND_SET, t0, 1'b1, 11'd1, 31'd0));
				queue_item(ev(sst_pkg::KIND_REQUEST, t0, 1'b1, 11'd0, 31'd0));
				queue_item(ev(sst_pkg::KIND_TICK, t0 + 60000, 1'b1, 11'd0, 31'd0));
			end
			END_BOTH_CMDS: begin
				queue_item(ev(sst_pkg::KIND_REQUEST, t0, 1'b1, 11'd0, 31'h7FFF_FFFF));
				queue_item(ev(sst_pkg::KIND_SET, t0, 1'b1, 11'd1, 31'd0));
				queue_item(ev(sst_pkg::KIND_TICK, t0 + 60000, 1'b1, 11'd0, 31'd0));
			end
			END_SLEEP: begin
				queue_item(ev(sst_pkg::KIND_REQUEST, t0, 1'b0, 11'd0, 31'h7FFF_FFFF));
				queue_item(ev(sst_pkg::KIND_SET, t0, 1'b0, 11'd1, 31'd0));
				queue_item(ev(sst_pkg::KIND_TICK, t0 + 60000, 1'b0, 11'd0, 31'd0));
			end
			default: begin
				queue_item(ev(sst_pkg::KIND_REQUEST, t0, 1'b1, 11'd0, 31'd5000));
				queue_item(ev(sst_pkg::KIND_CANCEL, t0, 1'b1, 11'd0, 31'd0));
				queue_item(ev(sst_pkg::KIND_TICK, t0 + 5000, 1'b1, 11'd0, 31'd0));
			end
		endcase
		queue_item(ev(sst_pkg::KIND_SET, t0 + 70000, 1'b1, 11'd1440, 31'd0));
		queue_item(ev(sst_pkg::KIND_REQUEST, t0 + 70000, 1'b1, 11'd0, 31'd0));
		queue_item(ev(sst_pkg::KIND_CYCLE, t0 + 71000, 1'b1, 11'd0, 31'd0));
		queue_item(ev(sst_pkg::KIND_ACTIVITY, t0 + 72000, 1'b1, 11'd0, 31'd0));
		queue_item(ev(sst_pkg::KIND_TICK, t0 + 32'd10_000_000, 1'b1, 11'd0, 31'd0));
		wait_drained();

		$display("Run: %0d items in, %0d status items checked, %0d screen-off commands.",
			items_sent, status_seen, scr_cmds);
		$display("Saturated countdowns %0d, closing shutdown cause %0d (%s), %0d mismatches.",
			sat_seen, end_cause, finale.name(), mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Timeout at %0t with %0d status items outstanding", $time, status_due_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
